// ----- rtl/core/bsap_pkg.sv -----
// ----------------------------------------------------------------------------
// bsap_pkg
// Shared widths, request and register codes, and the command and status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bsap_pkg;

  localparam int REQ_W      = 3;
  localparam int INDEX_W    = 10;
  localparam int VALUE_W    = 11;
  localparam int HEAD_W     = 6;
  localparam int ROW_W      = 6;
  localparam int COUNT_W    = 12;
  localparam int VCNT_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [VCNT_W-1:0] VCNT_RESET = 7'd64;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_A_START = 3'd0;
  localparam logic [REQ_W-1:0] REQ_A_HEAD  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_B_START = 3'd2;
  localparam logic [REQ_W-1:0] REQ_B_HEAD  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 3'd4;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_ARCS    = 1'b1;

  typedef struct packed {
    logic wr;        // store a load item into its table
    logic take_row;  // latch the row of a compute item
    logic start;     // reset the mask and pending result for a new row
    logic b_range;   // latch the bounds of a B row
    logic b_inc;     // step the B arc pointer
    logic a_range;   // latch the bounds of the A row
    logic a_inc;     // step the A arc pointer
    logic load_u;    // take an A head as the next B row
    logic emit;      // record a new product arc
    logic finish;    // close the row with its last result or marker
  } bsap_cmd_t;

  typedef struct packed {
    logic req_compute;
    logic row_ok;
    logic self_arcs;
    logic b_more;
    logic w_new;
    logic a_more;
    logic u_ok;
    logic pend_valid;
    logic out_free;
  } bsap_sts_t;

endpackage

// ----- rtl/core/bsap_ifs.sv -----
// ----------------------------------------------------------------------------
// bsap channel interfaces
// Request, result and configuration write channels with valid and ready.
// ----------------------------------------------------------------------------
interface bsap_req_if;
  logic                           valid;
  logic                           ready;
  logic [bsap_pkg::REQ_W-1:0]     req_type;
  logic [bsap_pkg::INDEX_W-1:0]   index;
  logic [bsap_pkg::VALUE_W-1:0]   value;
  modport source (output valid, req_type, index, value, input ready);
  modport sink   (input valid, req_type, index, value, output ready);
endinterface

interface bsap_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [bsap_pkg::HEAD_W-1:0]    head_vertex;
  logic [bsap_pkg::ROW_W-1:0]     row;
  logic                           valid_res;
  logic                           last;
  logic [bsap_pkg::COUNT_W-1:0]   running_count;
  modport source (output valid, head_vertex, row, valid_res, last, running_count,
                  input ready);
  modport sink   (input valid, head_vertex, row, valid_res, last, running_count,
                  output ready);
endinterface

interface bsap_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bsap_pkg::CFG_IDX_W-1:0]   addr;
  logic [bsap_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ----- rtl/core/bsap_ctrl.sv -----
// ----------------------------------------------------------------------------
// bsap_ctrl
// Sequencer that walks the A row and the matching B rows of one compute item.
// ----------------------------------------------------------------------------
module bsap_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bsap_pkg::bsap_sts_t sts,
  output bsap_pkg::bsap_cmd_t cmd
);
  import bsap_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_B_RS    = 4'd1;
  localparam logic [3:0] S_B_RANGE = 4'd2;
  localparam logic [3:0] S_B_HD    = 4'd3;
  localparam logic [3:0] S_B_CHK   = 4'd4;
  localparam logic [3:0] S_A_RS    = 4'd5;
  localparam logic [3:0] S_A_RANGE = 4'd6;
  localparam logic [3:0] S_A_HD    = 4'd7;
  localparam logic [3:0] S_A_CHK   = 4'd8;
  localparam logic [3:0] S_FINAL   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       in_a_loop;       // set while B rows come from A heads
  logic       in_a_loop_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    in_a_loop_next = in_a_loop;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.req_compute) begin
            cmd.take_row = 1'b1;
            if (sts.row_ok) begin
              cmd.start = 1'b1;
              if (sts.self_arcs) begin
                in_a_loop_next = 1'b0;
                state_next     = S_B_RS;
              end else begin
                state_next = S_A_RS;
              end
            end else begin
              state_next = S_FINAL;
            end
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_B_RS:    state_next = S_B_RANGE;
      S_B_RANGE: begin
        cmd.b_range = 1'b1;
        state_next  = S_B_HD;
      end
      S_B_HD: begin
        if (sts.b_more) begin
          state_next = S_B_CHK;
        end else if (in_a_loop) begin
          state_next = S_A_HD;
        end else begin
          state_next = S_A_RS;
        end
      end
      S_B_CHK: begin
        if (!sts.w_new) begin
          cmd.b_inc  = 1'b1;
          state_next = S_B_HD;
        end else if (!sts.pend_valid || sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.b_inc  = 1'b1;
          state_next = S_B_HD;
        end
      end
      S_A_RS:    state_next = S_A_RANGE;
      S_A_RANGE: begin
        cmd.a_range = 1'b1;
        state_next  = S_A_HD;
      end
      S_A_HD: begin
        if (sts.a_more) begin
          state_next = S_A_CHK;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_A_CHK: begin
        cmd.a_inc = 1'b1;
        if (sts.u_ok) begin
          cmd.load_u     = 1'b1;
          in_a_loop_next = 1'b1;
          state_next     = S_B_RS;
        end else begin
          state_next = S_A_HD;
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_a_loop <= 1'b0;
    end else begin
      state     <= state_next;
      in_a_loop <= in_a_loop_next;
    end
  end

endmodule

// ----- rtl/core/bsap_dp.sv -----
// ----------------------------------------------------------------------------
// bsap_dp
// Graph tables, arc pointers, visited mask, running count, a one-deep
// pending result and the output register.
// ----------------------------------------------------------------------------
module bsap_dp #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_ARCS     = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bsap_pkg::REQ_W-1:0]    req_type,
  input  logic [bsap_pkg::INDEX_W-1:0]  index,
  input  logic [bsap_pkg::VALUE_W-1:0]  value,
  bsap_cfg_if.sink                      cfg,
  bsap_rsp_if.source                    rsp,
  input  bsap_pkg::bsap_cmd_t           cmd,
  output bsap_pkg::bsap_sts_t           sts
);
  import bsap_pkg::*;

  localparam int RW = $clog2(MAX_VERTICES + 1);
  localparam int AW = $clog2(MAX_ARCS);
  localparam int VW = $clog2(MAX_VERTICES);

  // Tables.
  logic [VALUE_W-1:0] a_rs [MAX_VERTICES+1];
  logic [VALUE_W-1:0] b_rs [MAX_VERTICES+1];
  logic [HEAD_W-1:0]  a_hd [MAX_ARCS];
  logic [HEAD_W-1:0]  b_hd [MAX_ARCS];

  logic [VALUE_W-1:0] a_rs_q0, a_rs_q1, b_rs_q0, b_rs_q1;
  logic [HEAD_W-1:0]  a_hd_q, b_hd_q;

  // Configuration and row state.
  logic [VCNT_W-1:0]       vcount;
  logic                    self_arcs;
  logic [VCNT_W-1:0]       n_eff;
  logic [MAX_VERTICES-1:0] mask;
  logic [MAX_VERTICES-1:0] start_mask;
  logic [COUNT_W-1:0]      total;
  logic [ROW_W-1:0]        v_reg, u_reg;
  logic [VALUE_W-1:0]      bi, be, ai, ae;
  logic                    pend_valid;
  logic [HEAD_W-1:0]       pend_head;
  logic [COUNT_W-1:0]      pend_count;

  logic                    out_valid;
  logic [HEAD_W-1:0]       res_head;
  logic [ROW_W-1:0]        out_row;
  logic                    out_valid_res;
  logic                    out_last;
  logic [COUNT_W-1:0]      out_count;

  logic [31:0] idx_ext, v_ext, v1_ext, u_ext, u1_ext, ai_ext, bi_ext, w_ext;
  logic        rs_wr_ok, hd_wr_ok, out_free;

  always_comb begin
    if (vcount == '0) begin
      n_eff = VCNT_W'(1);
    end else if (32'(vcount) > 32'(MAX_VERTICES)) begin
      n_eff = VCNT_W'(MAX_VERTICES);
    end else begin
      n_eff = vcount;
    end
  end

  always_comb begin
    idx_ext  = 32'(index);
    v_ext    = 32'(v_reg);
    v1_ext   = v_ext + 32'd1;
    u_ext    = 32'(u_reg);
    u1_ext   = u_ext + 32'd1;
    ai_ext   = 32'(ai);
    bi_ext   = 32'(bi);
    w_ext    = 32'(b_hd_q);
    rs_wr_ok = (idx_ext <= 32'(MAX_VERTICES)) && (32'(value) <= 32'(MAX_ARCS));
    hd_wr_ok = (idx_ext < 32'(MAX_ARCS)) && (32'(value) < 32'(MAX_VERTICES));
    start_mask = '0;
    start_mask[idx_ext[VW-1:0]] = 1'b1;
  end

  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    sts.req_compute = (req_type == REQ_COMPUTE);
    sts.row_ok      = idx_ext < 32'(n_eff);
    sts.self_arcs   = self_arcs;
    sts.b_more      = (bi < be) && (bi_ext < 32'(MAX_ARCS));
    sts.w_new       = (w_ext < 32'(n_eff)) && !mask[w_ext[VW-1:0]];
    sts.a_more      = (ai < ae) && (ai_ext < 32'(MAX_ARCS));
    sts.u_ok        = 32'(a_hd_q) < 32'(n_eff);
    sts.pend_valid  = pend_valid;
    sts.out_free    = out_free;
  end

  // Table writes and registered reads.
  always_ff @(posedge clk) begin
    if (cmd.wr && rs_wr_ok && req_type == REQ_A_START) begin
      a_rs[idx_ext[RW-1:0]] <= value;
    end
    if (cmd.wr && rs_wr_ok && req_type == REQ_B_START) begin
      b_rs[idx_ext[RW-1:0]] <= value;
    end
    if (cmd.wr && hd_wr_ok && req_type == REQ_A_HEAD) begin
      a_hd[idx_ext[AW-1:0]] <= value[HEAD_W-1:0];
    end
    if (cmd.wr && hd_wr_ok && req_type == REQ_B_HEAD) begin
      b_hd[idx_ext[AW-1:0]] <= value[HEAD_W-1:0];
    end
    a_rs_q0 <= a_rs[v_ext[RW-1:0]];
    a_rs_q1 <= a_rs[v1_ext[RW-1:0]];
    b_rs_q0 <= b_rs[u_ext[RW-1:0]];
    b_rs_q1 <= b_rs[u1_ext[RW-1:0]];
    a_hd_q  <= a_hd[ai_ext[AW-1:0]];
    b_hd_q  <= b_hd[bi_ext[AW-1:0]];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount      <= VCNT_RESET;
      self_arcs   <= 1'b0;
      mask        <= '0;
      total       <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.addr)
          CFG_VERTEX_COUNT: vcount    <= cfg.data;
          CFG_SELF_ARCS:    self_arcs <= cfg.data[0];
          default:          vcount    <= vcount;
        endcase
      end
      // The output stage fills when a row closes or when a new arc pushes the
      // pending one out, and empties when the sink takes it.
      if (cmd.finish || (cmd.emit && pend_valid)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.start) begin
        mask       <= start_mask;
        pend_valid <= 1'b0;
        if (index == '0) begin
          total <= '0;
        end
      end
      if (cmd.emit) begin
        mask[w_ext[VW-1:0]] <= 1'b1;
        total      <= total + COUNT_W'(1);
        pend_valid <= 1'b1;
      end
      if (cmd.finish) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Pointers, pending result and output payload.
  always_ff @(posedge clk) begin
    if (cmd.take_row) begin
      v_reg <= index[ROW_W-1:0];
      u_reg <= index[ROW_W-1:0];
    end
    if (cmd.load_u) begin
      u_reg <= a_hd_q;
    end
    if (cmd.b_range) begin
      bi <= b_rs_q0;
      be <= b_rs_q1;
    end
    if (cmd.b_inc) begin
      bi <= bi + VALUE_W'(1);
    end
    if (cmd.a_range) begin
      ai <= a_rs_q0;
      ae <= a_rs_q1;
    end
    if (cmd.a_inc) begin
      ai <= ai + VALUE_W'(1);
    end
    if (cmd.emit) begin
      pend_head  <= b_hd_q;
      pend_count <= total + COUNT_W'(1);
      // Only a displaced pending arc reaches the output stage; otherwise a
      // result still waiting there must stay as it is.
      if (pend_valid) begin
        res_head      <= pend_head;
        out_row       <= v_reg;
        out_valid_res <= 1'b1;
        out_last      <= 1'b0;
        out_count     <= pend_count;
      end
    end
    if (cmd.finish) begin
      out_row  <= v_reg;
      out_last <= 1'b1;
      if (pend_valid) begin
        res_head      <= pend_head;
        out_valid_res <= 1'b1;
        out_count     <= pend_count;
      end else begin
        res_head      <= '0;
        out_valid_res <= 1'b0;
        out_count     <= total;
      end
    end
  end

  assign cfg.ready         = 1'b1;
  assign rsp.valid         = out_valid;
  assign rsp.head_vertex   = res_head;
  assign rsp.row           = out_row;
  assign rsp.valid_res     = out_valid_res;
  assign rsp.last          = out_last;
  assign rsp.running_count = out_count;

  // A new arc never displaces a pending one into an occupied output stage.
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && pend_valid) |-> out_free)
    else $error("pending result pushed into a full output stage");

  // Closing a row always empties the pending slot.
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> !pend_valid)
    else $error("pending result survived the end of its row");

  // An empty-row marker is always the last result of its row.
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_valid_res) |-> (out_last && res_head == '0))
    else $error("malformed empty-row marker");

endmodule

// ----- rtl/core/boolean_sparse_adjacency_product.sv -----
// ----------------------------------------------------------------------------
// boolean_sparse_adjacency_product
// Boolean product of two compressed-row graphs, emitted one row at a time.
// ----------------------------------------------------------------------------
// Load items (A or B row starts and arc heads) are taken while the controller
// is idle, produce no result and do not hold up the item behind them. A
// compute item for row v walks one B row for each A head of v below the
// vertex count, plus row v itself when the self-arc register is set; a row
// outside the vertex count goes straight to the closing state and gives an
// empty-row marker. Every table is read through a register, so each
// row-start pair passes a wait state and a latch state, each arc an address
// state and a check state, and the acceptance, the end of each B row, the end
// of the A row and the closing of the row each pass through a state as well.
// The walk stalls in the check and closing states while the sink holds the
// output stage. Results leave through a registered output stage; the newest
// found arc waits in a one-deep pending slot so that the last flag can be
// placed on it when the row ends. A new item is taken only when the previous
// compute row has been fully handed to the output stage. Configuration
// writes are taken in every cycle.
module boolean_sparse_adjacency_product #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_ARCS     = 1024
) (
  input  logic       clk,
  input  logic       rst,
  bsap_cfg_if.sink   cfg,
  bsap_req_if.sink   req,
  bsap_rsp_if.source rsp
);
  import bsap_pkg::*;

  bsap_cmd_t cmd;
  bsap_sts_t sts;
  logic      in_ready;

  // The controller decides when an item is taken and steps the row walk.
  bsap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath owns the tables, the visited mask and the running count.
  bsap_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_ARCS     (MAX_ARCS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req_type (req.req_type),
    .index    (req.index),
    .value    (req.value),
    .cfg      (cfg),
    .rsp      (rsp),
    .cmd      (cmd),
    .sts      (sts)
  );

  assign req.ready = in_ready;

endmodule

// ----- dv/tb_boolean_sparse_adjacency_product.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_boolean_sparse_adjacency_product
// Self-checking bench for the boolean sparse adjacency product block. Loads
// and compute requests go in through the request channel. An in-bench model
// of the graph tables predicts every product arc and empty-row marker, and
// each result transfer is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_boolean_sparse_adjacency_product;
  import bsap_pkg::*;

  localparam int MAX_V     = 64;
  localparam int MAX_A     = 1024;
  localparam int LIMIT     = 4000000;
  localparam int PHASES    = 6;
  localparam int RAND_ITEMS = 370;

  typedef struct packed {
    logic [HEAD_W-1:0]  head;
    logic [ROW_W-1:0]   row;
    logic               vres;
    logic               last;
    logic [COUNT_W-1:0] count;
  } arc_res_t;

  // Holds the bench's own copy of both graphs, the visited mask, the running
  // arc count and the registers, and queues the arcs each compute should give.
  class product_scoreboard;
    logic [VALUE_W-1:0] a_start [MAX_V+1];
    logic [VALUE_W-1:0] b_start [MAX_V+1];
    logic [HEAD_W-1:0]  a_head  [MAX_A];
    logic [HEAD_W-1:0]  b_head  [MAX_A];
    bit                 a_start_wr [MAX_V+1];
    bit                 b_start_wr [MAX_V+1];
    bit                 a_head_wr  [MAX_A];
    bit                 b_head_wr  [MAX_A];
    logic [63:0]        visited;
    logic [COUNT_W-1:0] arc_total;
    logic [VCNT_W-1:0]  vcount;
    logic               loops;
    arc_res_t           expected_arcs [$];
    arc_res_t           row_arcs [$];
    int                 errors;
    int                 checked;

    function new();
      visited   = '0;
      arc_total = '0;
      vcount    = VCNT_RESET;
      loops     = 1'b0;
      errors    = 0;
      checked   = 0;
    endfunction

    function int eff_n();
      if (vcount == 0) return 1;
      if (vcount > MAX_V) return MAX_V;
      return int'(vcount);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      if (addr == CFG_VERTEX_COUNT) vcount = data;
      else if (addr == CFG_SELF_ARCS) loops = data[0];
    endfunction

    // Returns the first table entry a B row walk would read before it was
    // written, coded as request type and index, or -1 when all are defined.
    function int b_gap(int u);
      int s, e;
      if (u >= eff_n()) return -1;
      if (!b_start_wr[u]) return (int'(REQ_B_START) << 11) | u;
      if (!b_start_wr[u+1]) return (int'(REQ_B_START) << 11) | (u + 1);
      s = int'(b_start[u]);
      e = int'(b_start[u+1]);
      for (int i = s; i < e && i < MAX_A; i++)
        if (!b_head_wr[i]) return (int'(REQ_B_HEAD) << 11) | i;
      return -1;
    endfunction

    function int first_gap(int v);
      int s, e, g;
      if (v >= eff_n()) return -1;
      if (loops) begin
        g = b_gap(v);
        if (g >= 0) return g;
      end
      if (!a_start_wr[v]) return (int'(REQ_A_START) << 11) | v;
      if (!a_start_wr[v+1]) return (int'(REQ_A_START) << 11) | (v + 1);
      s = int'(a_start[v]);
      e = int'(a_start[v+1]);
      for (int i = s; i < e && i < MAX_A; i++) begin
        if (!a_head_wr[i]) return (int'(REQ_A_HEAD) << 11) | i;
        g = b_gap(int'(a_head[i]));
        if (g >= 0) return g;
      end
      return -1;
    endfunction

    function void walk_b_row(int u, int v);
      int s, e, w;
      arc_res_t r;
      if (u >= eff_n()) return;
      s = int'(b_start[u]);
      e = int'(b_start[u+1]);
      for (int i = s; i < e && i < MAX_A; i++) begin
        w = int'(b_head[i]);
        if (w >= eff_n() || visited[w]) continue;
        visited[w] = 1'b1;
        arc_total  = arc_total + COUNT_W'(1);
        r.head  = w[HEAD_W-1:0];
        r.row   = v[ROW_W-1:0];
        r.vres  = 1'b1;
        r.last  = 1'b0;
        r.count = arc_total;
        row_arcs.push_back(r);
      end
    endfunction

    function void note_item(logic [REQ_W-1:0] kind, logic [INDEX_W-1:0] idx,
                            logic [VALUE_W-1:0] val);
      int v, s, e;
      arc_res_t r;
      case (kind)
        REQ_A_START, REQ_B_START: begin
          if (idx <= MAX_V && val <= MAX_A) begin
            if (kind == REQ_A_START) begin
              a_start[idx] = val; a_start_wr[idx] = 1'b1;
            end else begin
              b_start[idx] = val; b_start_wr[idx] = 1'b1;
            end
          end
        end
        REQ_A_HEAD, REQ_B_HEAD: begin
          if (val < MAX_V) begin
            if (kind == REQ_A_HEAD) begin
              a_head[idx] = val[HEAD_W-1:0]; a_head_wr[idx] = 1'b1;
            end else begin
              b_head[idx] = val[HEAD_W-1:0]; b_head_wr[idx] = 1'b1;
            end
          end
        end
        REQ_COMPUTE: begin
          v = int'(idx);
          row_arcs.delete();
          if (v < eff_n()) begin
            if (v == 0) arc_total = '0;
            visited = 64'd1 << v;
            if (loops) walk_b_row(v, v);
            s = int'(a_start[v]);
            e = int'(a_start[v+1]);
            for (int i = s; i < e && i < MAX_A; i++) walk_b_row(int'(a_head[i]), v);
          end
          if (row_arcs.size() == 0) begin
            r.head  = '0;
            r.row   = idx[ROW_W-1:0];
            r.vres  = 1'b0;
            r.last  = 1'b1;
            r.count = arc_total;
            row_arcs.push_back(r);
          end else begin
            row_arcs[row_arcs.size()-1].last = 1'b1;
          end
          foreach (row_arcs[k]) expected_arcs.push_back(row_arcs[k]);
        end
        default: ;
      endcase
    endfunction

    function void check(arc_res_t got);
      arc_res_t want;
      checked++;
      if (expected_arcs.size() == 0) begin
        $error("unexpected result: head_vertex %0d row %0d", got.head, got.row);
        errors++;
        return;
      end
      want = expected_arcs.pop_front();
      if (got.head !== want.head) begin
        $error("head_vertex: expected %0d, actual %0d", want.head, got.head); errors++;
      end
      if (got.row !== want.row) begin
        $error("row: expected %0d, actual %0d", want.row, got.row); errors++;
      end
      if (got.vres !== want.vres) begin
        $error("valid_res: expected %0d, actual %0d", want.vres, got.vres); errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last); errors++;
      end
      if (got.count !== want.count) begin
        $error("running_count: expected %0d, actual %0d", want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  bsap_cfg_if cfg ();
  bsap_req_if req ();
  bsap_rsp_if rsp ();

  boolean_sparse_adjacency_product u_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

  product_scoreboard arcs_sb = new();

  int cycle_count = 0;
  int items_sent  = 0;
  int rows_sent   = 0;
  int burst_left  = 0;
  bit long_hold_done = 1'b0;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // The cycle counter guards against a hang anywhere in the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: every transfer is checked at the rising edge, with values
  // as they stood before the edge updates them.
  always @(posedge clk) begin
    arc_res_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got.head  = rsp.head_vertex;
      got.row   = rsp.row;
      got.vres  = rsp.valid_res;
      got.last  = rsp.last;
      got.count = rsp.running_count;
      arcs_sb.check(got);
    end
  end

  // The receiver switches among three stall patterns, drawn at random: always
  // ready, random stalls, and a regular one-in-four stall. Once, well into
  // the run, it holds off for a long stretch so that the block backs up and
  // the request channel stalls while the sender keeps offering items.
  initial begin
    int mode;
    mode = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && items_sent >= 120) begin
        long_hold_done = 1'b1;
        rsp.ready = 1'b0;
        repeat (400) @(negedge clk);
      end
      if (cycle_count % 64 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0:       rsp.ready = 1'b1;
        1:       rsp.ready = ($urandom_range(0, 9) < 6);
        default: rsp.ready = (cycle_count % 4 != 0);
      endcase
    end
  end

  // Sends one request. The sender works in bursts of random length, with a
  // gap of random length between bursts; the transfer is noted in the
  // model only once valid and ready have met at a rising edge.
  task automatic send_item(logic [REQ_W-1:0] kind, logic [INDEX_W-1:0] idx,
                           logic [VALUE_W-1:0] val);
    if (burst_left == 0) begin
      @(negedge clk);
      req.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end else begin
      @(negedge clk);
    end
    req.valid    = 1'b1;
    req.req_type = kind;
    req.index    = idx;
    req.value    = val;
    do @(posedge clk); while (!req.ready);
    arcs_sb.note_item(kind, idx, val);
    items_sent++;
    burst_left--;
  endtask

  // Before a compute goes out, every table entry it would read is loaded,
  // so that no read ever lands on an entry that was never written.
  task automatic compute_row(int v);
    int gap, n;
    logic [REQ_W-1:0] kind;
    logic [VALUE_W-1:0] val;
    n = arcs_sb.eff_n();
    gap = arcs_sb.first_gap(v);
    while (gap >= 0) begin
      kind = REQ_W'(gap >> 11);
      if (kind == REQ_A_START || kind == REQ_B_START)
        val = VALUE_W'($urandom_range(0, 24));
      else if ($urandom_range(0, 9) < 7)
        val = VALUE_W'($urandom_range(0, n - 1));
      else
        val = VALUE_W'($urandom_range(0, MAX_V - 1));
      send_item(kind, INDEX_W'(gap & 2047), val);
      gap = arcs_sb.first_gap(v);
    end
    send_item(REQ_COMPUTE, INDEX_W'(v), VALUE_W'($urandom_range(0, 2047)));
    rows_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.addr  = addr;
    cfg.data  = data;
    do @(posedge clk); while (!cfg.ready);
    arcs_sb.write_reg(addr, data);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // Loads give no result, so once the queue drains the block is still given
  // time for a last load or two before anything else is changed.
  task automatic wait_drained();
    @(negedge clk);
    req.valid  = 1'b0;
    burst_left = 0;
    while (arcs_sb.expected_arcs.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic directed_items();
    // Unknown request types are dropped without a result.
    send_item(3'd5, '0, '0);
    send_item(3'd6, 10'd1023, 11'd2047);
    send_item(3'd7, 10'd512, 11'd1024);
    // Loads with an index or value out of range are ignored, bar the last one.
    send_item(REQ_A_START, 10'd65, 11'd3);
    send_item(REQ_B_START, 10'd1023, 11'd5);
    send_item(REQ_A_START, 10'd3, 11'd1025);
    send_item(REQ_B_HEAD, 10'd5, 11'd64);
    send_item(REQ_B_HEAD, 10'd1023, 11'd2047);
    send_item(REQ_A_HEAD, 10'd1023, 11'd63);
    // B row 62 sits at the very top of the arc table and holds a self loop
    // and a duplicate, both of which must be dropped.
    send_item(REQ_B_START, 10'd62, 11'd1020);
    send_item(REQ_B_START, 10'd63, 11'd1024);
    send_item(REQ_B_HEAD, 10'd1020, 11'd62);
    send_item(REQ_B_HEAD, 10'd1021, 11'd0);
    send_item(REQ_B_HEAD, 10'd1022, 11'd63);
    send_item(REQ_B_HEAD, 10'd1023, 11'd0);
    send_item(REQ_A_START, 10'd62, 11'd0);
    send_item(REQ_A_START, 10'd63, 11'd1);
    send_item(REQ_A_START, 10'd64, 11'd0);
    send_item(REQ_A_HEAD, 10'd0, 11'd62);
    // Row zero clears the count; row 63 has a reversed range and gives a
    // marker; row 1023 is beyond the vertex count.
    compute_row(0);
    compute_row(62);
    compute_row(63);
    compute_row(1023);
  endtask

  task automatic random_item();
    int r, n;
    n = arcs_sb.eff_n();
    r = $urandom_range(0, 99);
    if (r < 55) begin
      if ($urandom_range(0, 5) == 0)      compute_row(0);
      else if ($urandom_range(0, 7) == 0) compute_row($urandom_range(0, 1023));
      else                                compute_row($urandom_range(0, n - 1));
    end else if (r < 70) begin
      send_item($urandom_range(0, 1) ? REQ_A_START : REQ_B_START,
                INDEX_W'(($urandom_range(0, 11) == 0) ? $urandom_range(0, 1023)
                                                      : $urandom_range(0, MAX_V)),
                VALUE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                     : $urandom_range(0, 24)));
    end else if (r < 92) begin
      send_item($urandom_range(0, 1) ? REQ_A_HEAD : REQ_B_HEAD,
                INDEX_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                     : $urandom_range(0, 47)),
                VALUE_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                     : $urandom_range(0, n - 1)));
    end else begin
      send_item(REQ_W'($urandom_range(5, 7)), INDEX_W'($urandom_range(0, 1023)),
                VALUE_W'($urandom_range(0, 2047)));
    end
  endtask

  initial begin
    int vsel [PHASES];
    int lsel [PHASES];
    vsel = '{64, 64, 1, 0, 127, 0};
    lsel = '{0, 1, 1, 0, 1, 0};
    vsel[PHASES-1] = $urandom_range(2, 63);
    lsel[PHASES-1] = $urandom_range(0, 1);

    rst          = 1'b1;
    cfg.valid    = 1'b0;
    cfg.addr     = '0;
    cfg.data     = '0;
    req.valid    = 1'b0;
    req.req_type = '0;
    req.index    = '0;
    req.value    = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Each phase runs under its own register setting, written while idle,
    // and sends its share of the request budget, table fills included.
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) wait_drained();
      write_reg(CFG_VERTEX_COUNT, CFG_DATA_W'(vsel[p]));
      write_reg(CFG_SELF_ARCS, CFG_DATA_W'(lsel[p]));
      if (p == 0) directed_items();
      while (items_sent < ((p + 1) * RAND_ITEMS) / PHASES) random_item();
    end

    wait_drained();
    $display("covered %0d requests, %0d compute rows and %0d results over %0d settings",
             items_sent, rows_sent, arcs_sb.checked, PHASES);
    $display("mismatches: %0d, cycles: %0d", arcs_sb.errors, cycle_count);
    if (arcs_sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- boolean_sparse_adjacency_product.f -----
rtl/core/bsap_pkg.sv
rtl/core/bsap_ifs.sv
rtl/core/bsap_ctrl.sv
rtl/core/bsap_dp.sv
rtl/core/boolean_sparse_adjacency_product.sv
dv/tb_boolean_sparse_adjacency_product.sv
